// ----- rtl/core/ctc_pkg.sv -----
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types and constants for the compact target codec: transfer
// payload structs, operation codes and field widths.
// ----------------------------------------------------------------------------
package ctc_pkg;

  localparam int ValueW    = 256;  // full value width
  localparam int LimbW     = 64;   // one value limb
  localparam int CompactW  = 32;   // compact word
  localparam int MantW     = 23;   // mantissa field
  localparam int Mant24W   = 24;   // extracted mantissa before renormalize
  localparam int ExpW      = 8;    // exponent field
  localparam int ByteLenW  = 6;    // byte length 0..32
  localparam int ByteShW   = 5;    // byte shift 0..31

  // operation codes
  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  // input transfer
  typedef struct packed {
    logic                opcode;
    logic [CompactW-1:0] compact_in;
    logic                sign_request;
    logic [LimbW-1:0]    value_in_0;
    logic [LimbW-1:0]    value_in_1;
    logic [LimbW-1:0]    value_in_2;
    logic [LimbW-1:0]    value_in_3;
  } in_item_t;

  // result transfer
  typedef struct packed {
    logic [LimbW-1:0]    value_out_0;
    logic [LimbW-1:0]    value_out_1;
    logic [LimbW-1:0]    value_out_2;
    logic [LimbW-1:0]    value_out_3;
    logic                negative_flag;
    logic                overflow_flag;
    logic [CompactW-1:0] compact_out;
  } out_item_t;

endpackage

// ----- rtl/core/ctc_byte_len.sv -----
// ----------------------------------------------------------------------------
// ctc_byte_len
// Byte length of a 256-bit value: position of the highest nonzero byte
// plus one, zero for a zero value.
// ----------------------------------------------------------------------------
module ctc_byte_len (
  input  logic [ctc_pkg::ValueW-1:0]   value,
  output logic [ctc_pkg::ByteLenW-1:0] len
);
  import ctc_pkg::*;

  localparam int NumBytes = ValueW / 8;

  logic [NumBytes-1:0] nz;

  // per-byte nonzero detect
  always_comb begin
    for (int i = 0; i < NumBytes; i++) begin
      nz[i] = |value[8*i +: 8];
    end
  end

  // priority encode from the bottom byte up (last hit, the top nonzero byte, wins)
  always_comb begin
    len = '0;
    for (int i = 0; i < NumBytes; i++) begin
      if (nz[i]) begin
        len = ByteLenW'(i + 1);
      end
    end
  end

endmodule

// ----- rtl/core/compact_target_codec.sv -----
// ----------------------------------------------------------------------------
// compact_target_codec
// Three register stages (stage 1, stage 2 and the result register), the first
// loaded at the input transfer edge.
// Throughput: one item per cycle while unstalled; stages advance independently on stall.
// Reset: synchronous, clears the stage valid bits only; the codec keeps no state.
// Decode expands a compact word to 256 bits with sign and overflow flags;
// encode packs a 256-bit value into a compact word.
// ----------------------------------------------------------------------------
module compact_target_codec (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  ctc_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output ctc_pkg::out_item_t result
);
  import ctc_pkg::*;

  // ---------------- pipeline control ----------------
  logic v1, v2, v3;
  logic en1, en2, en3;

  assign en3        = !v3 || result_ready;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign item_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= item_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // ---------------- stage 1: exponent decode, byte length ----------------
  logic [ExpW-1:0]     size;
  logic [MantW-1:0]    word;
  logic [MantW-1:0]    word_s;
  logic [MantW-1:0]    d_word_next;
  logic [ByteShW-1:0]  d_lsh_next;
  logic                neg_next, ovf_next;
  logic [ValueW-1:0]   enc_value;
  logic [ByteLenW-1:0] enc_len;

  assign size      = item.compact_in[31:24];
  assign word      = item.compact_in[MantW-1:0];
  assign enc_value = {item.value_in_3, item.value_in_2, item.value_in_1, item.value_in_0};

  always_comb begin
    word_s      = word;
    d_word_next = word;
    d_lsh_next  = '0;
    if (size <= 8'd3) begin
      // small exponent: shift mantissa right by whole bytes
      word_s      = word >> {2'd3 - size[1:0], 3'b000};
      d_word_next = word_s;
    end else if (size <= 8'd34) begin
      d_lsh_next = ByteShW'(size - 8'd3);
    end else begin
      // shift of 256 or more clears the value
      d_word_next = '0;
    end
    neg_next = (word_s != '0) && item.compact_in[MantW];
    ovf_next = (word_s != '0) &&
               ((size > 8'd34) ||
                ((word_s > 23'h0000ff) && (size > 8'd33)) ||
                ((word_s > 23'h00ffff) && (size > 8'd32)));
  end

  ctc_byte_len u_byte_len (
    .value (enc_value),
    .len   (enc_len)
  );

  logic                s1_op, s1_sreq, s1_neg, s1_ovf;
  logic [MantW-1:0]    s1_word;
  logic [ByteShW-1:0]  s1_lsh;
  logic [ValueW-1:0]   s1_value;
  logic [ByteLenW-1:0] s1_len;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op    <= item.opcode;
      s1_sreq  <= item.sign_request;
      s1_neg   <= neg_next;
      s1_ovf   <= ovf_next;
      s1_word  <= d_word_next;
      s1_lsh   <= d_lsh_next;
      s1_value <= enc_value;
      s1_len   <= enc_len;
    end
  end

  // ---------------- stage 2: limb shift, mantissa window ----------------
  logic [ValueW-1:0]           coarse_next;
  logic [ValueW+Mant24W-1:0]   ext;
  logic [Mant24W-1:0]          mant_next;

  assign coarse_next = {{(ValueW-MantW){1'b0}}, s1_word} << {s1_lsh[4:3], 6'b0};
  // three zero bytes below the value let short values share the window select
  assign ext         = {s1_value, {Mant24W{1'b0}}};
  assign mant_next   = ext[{s1_len, 3'b000} +: Mant24W];

  logic                s2_op, s2_sreq, s2_neg, s2_ovf;
  logic [2:0]          s2_fine;
  logic [ValueW-1:0]   s2_value;
  logic [Mant24W-1:0]  s2_mant;
  logic [ByteLenW-1:0] s2_len;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_op    <= s1_op;
      s2_sreq  <= s1_sreq;
      s2_neg   <= s1_neg;
      s2_ovf   <= s1_ovf;
      s2_fine  <= s1_lsh[2:0];
      s2_value <= coarse_next;
      s2_mant  <= mant_next;
      s2_len   <= s1_len;
    end
  end

  // ---------------- stage 3: byte shift, renormalize, pack ----------------
  logic [ValueW-1:0]   fine_val;
  logic [Mant24W-1:0]  mant_n;
  logic [ExpW-1:0]     exp_n;
  logic [CompactW-1:0] packed_c;
  out_item_t           result_next;

  assign fine_val = s2_value << {s2_fine, 3'b000};

  always_comb begin
    mant_n = s2_mant;
    exp_n  = ExpW'(s2_len);
    if (s2_mant[Mant24W-1]) begin
      mant_n = s2_mant >> 8;
      exp_n  = ExpW'(s2_len) + 8'd1;
    end
    packed_c = {exp_n, s2_sreq && (mant_n[MantW-1:0] != '0), mant_n[MantW-1:0]};

    result_next = '0;
    if (s2_op == OP_ENCODE) begin
      result_next.compact_out = packed_c;
    end else begin
      result_next.value_out_0   = fine_val[0*LimbW +: LimbW];
      result_next.value_out_1   = fine_val[1*LimbW +: LimbW];
      result_next.value_out_2   = fine_val[2*LimbW +: LimbW];
      result_next.value_out_3   = fine_val[3*LimbW +: LimbW];
      result_next.negative_flag = s2_neg;
      result_next.overflow_flag = s2_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      result <= result_next;
    end
  end

  assign result_valid = v3;

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for compact_target_codec. Covers decode of compact words into
// 256-bit values with the sign and overflow flags, and encode of 256-bit
// values into compact words. A built-in predictor computes each result from
// the accepted input. A scoreboard compares every field in transfer order.
// Both handshakes see random stalls, a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctc_pkg::*;

  localparam logic [31:0] MANT_MASK    = 32'h007f_ffff;
  localparam logic [31:0] SIGN_BIT     = 32'h0080_0000;
  localparam int          EXP_OVF_ANY  = 34;   // any nonzero mantissa overflows above
  localparam int          EXP_OVF_2B   = 33;   // mantissa wider than one byte
  localparam int          EXP_OVF_3B   = 32;   // mantissa wider than two bytes
  localparam int          ONE_BYTE_MAX = 'hff;
  localparam int          TWO_BYTE_MAX = 'hffff;
  localparam int          IDLE_PCT     = 32;
  localparam int          SINK_HOLD    = 60;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          CYCLE_LIMIT  = 200000;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts each conversion and checks results in order
  // --------------------------------------------------------------------------
  class codec_scoreboard;
    out_item_t pending_results[$];
    int errors;
    int n_decode;
    int n_encode;
    int n_checked;

    function new();
      errors    = 0;
      n_decode  = 0;
      n_encode  = 0;
      n_checked = 0;
    endfunction

    // expected conversion of one input transfer
    function out_item_t convert_item(in_item_t it);
      out_item_t   r;
      logic [255:0] val;
      logic [255:0] sh;
      logic [23:0]  mant;
      logic [31:0]  word;
      int unsigned  expo;
      int unsigned  nbits;
      int unsigned  nbytes;
      r = '0;
      if (it.opcode == OP_DECODE) begin
        expo = it.compact_in[31:24];
        mant = {1'b0, it.compact_in[22:0]};
        if (expo <= 3) begin
          mant = mant >> (8 * (3 - expo));
          val  = {232'b0, mant};
        end else begin
          // shifts of 256 or more give zero
          val = {232'b0, mant} << (8 * (expo - 3));
        end
        r.value_out_0   = val[63:0];
        r.value_out_1   = val[127:64];
        r.value_out_2   = val[191:128];
        r.value_out_3   = val[255:192];
        r.negative_flag = (mant != 0) && it.compact_in[23];
        r.overflow_flag = (mant != 0) && ((expo > EXP_OVF_ANY) ||
                          (mant > ONE_BYTE_MAX && expo > EXP_OVF_2B) ||
                          (mant > TWO_BYTE_MAX && expo > EXP_OVF_3B));
      end else begin
        val   = {it.value_in_3, it.value_in_2, it.value_in_1, it.value_in_0};
        nbits = 0;
        for (int i = 0; i < 256; i++) begin
          if (val[i]) nbits = i + 1;
        end
        nbytes = (nbits + 7) / 8;
        if (nbytes <= 3) sh = val << (8 * (3 - nbytes));
        else sh = val >> (8 * (nbytes - 3));
        word = sh[31:0];
        // keep the mantissa positive: move down a byte when bit 23 is set
        if ((word & SIGN_BIT) != 0) begin
          word   = word >> 8;
          nbytes = nbytes + 1;
        end
        word = word | (32'(nbytes) << 24);
        if (it.sign_request && (word & MANT_MASK) != 0) word = word | SIGN_BIT;
        r.compact_out = word;
      end
      return r;
    endfunction

    function void note_input(in_item_t it);
      if (it.opcode == OP_DECODE) n_decode++;
      else n_encode++;
      pending_results = {pending_results, convert_item(it)};
    endfunction

    function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      cmp_field("value_out_0", want.value_out_0, got.value_out_0);
      cmp_field("value_out_1", want.value_out_1, got.value_out_1);
      cmp_field("value_out_2", want.value_out_2, got.value_out_2);
      cmp_field("value_out_3", want.value_out_3, got.value_out_3);
      cmp_field("negative_flag", 64'(want.negative_flag), 64'(got.negative_flag));
      cmp_field("overflow_flag", 64'(want.overflow_flag), 64'(got.overflow_flag));
      cmp_field("compact_out", 64'(want.compact_out), 64'(got.compact_out));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result;

  codec_scoreboard sb = new();
  int  cycle_count = 0;
  int  hold_wanted = 0;
  int  hold_done = 0;
  bit  sender_steady = 1'b0;
  bit  sink_steady = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  compact_target_codec DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // transfer monitor and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (item_valid && item_ready) sb.note_input(item);
      if (result_valid && result_ready) sb.check_result(result);
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, quiet stretches and requested hold-offs
  initial begin
    forever begin
      @(negedge clk);
      if (hold_done != hold_wanted) begin
        result_ready <= 1'b0;
        repeat (SINK_HOLD - 1) @(negedge clk);
        hold_done++;
      end else if (sink_steady) begin
        result_ready <= 1'b1;
      end else begin
        result_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [255:0] rand256();
    logic [255:0] r;
    for (int i = 0; i < 8; i++) r[32*i +: 32] = $urandom;
    return r;
  endfunction

  // unused fields carry random noise
  function automatic in_item_t noise_item();
    in_item_t     it;
    logic [255:0] n;
    n               = rand256();
    it.opcode       = OP_DECODE;
    it.compact_in   = $urandom;
    it.sign_request = $urandom_range(0, 1);
    it.value_in_0   = n[63:0];
    it.value_in_1   = n[127:64];
    it.value_in_2   = n[191:128];
    it.value_in_3   = n[255:192];
    return it;
  endfunction

  function automatic in_item_t decode_item(logic [31:0] c);
    in_item_t it;
    it            = noise_item();
    it.opcode     = OP_DECODE;
    it.compact_in = c;
    return it;
  endfunction

  function automatic in_item_t encode_item(logic [255:0] v, logic sreq);
    in_item_t it;
    it              = noise_item();
    it.opcode       = OP_ENCODE;
    it.sign_request = sreq;
    it.value_in_0   = v[63:0];
    it.value_in_1   = v[127:64];
    it.value_in_2   = v[191:128];
    it.value_in_3   = v[255:192];
    return it;
  endfunction

  function automatic in_item_t random_item();
    logic [31:0]  expo;
    logic [31:0]  mant;
    logic [255:0] v;
    int           nb;
    if ($urandom_range(0, 1) == 0) begin
      // exponents mostly 0 to 36, just past the overflow limits; mantissas of 1 to 3 bytes
      expo = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 36) : $urandom_range(0, 255);
      case ($urandom_range(0, 3))
        0:       mant = $urandom_range(0, ONE_BYTE_MAX);
        1:       mant = $urandom_range(0, TWO_BYTE_MAX);
        default: mant = $urandom & MANT_MASK;
      endcase
      return decode_item((expo << 24) | mant | ($urandom_range(0, 1) ? SIGN_BIT : 32'h0));
    end
    if ($urandom_range(0, 7) == 0) return encode_item(rand256(), $urandom_range(0, 1));
    // value of a random byte length with its top byte nonzero
    nb = $urandom_range(0, 32);
    v  = rand256() & ({256{1'b1}} >> (256 - 8 * nb));
    if (nb > 0) v[8 * nb - 1 - $urandom_range(0, 7)] = 1'b1;
    return encode_item(v, $urandom_range(0, 1));
  endfunction

  // --------------------------------------------------------------------------
  // Driving tasks (called and returning at a falling edge)
  // --------------------------------------------------------------------------
  task automatic send_item(in_item_t it);
    if (!sender_steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        item_valid <= 1'b0;
        @(negedge clk);
      end
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // random phase; quiet window has no sender gaps, and either a receiver
  // hold-off at its start or no receiver stalls either
  task automatic run_random(int count, int quiet_from, int quiet_to, bit with_hold);
    for (int i = 0; i < count; i++) begin
      sender_steady = (i >= quiet_from && i < quiet_to);
      sink_steady   = sender_steady && !with_hold;
      if (with_hold && i == quiet_from) hold_wanted++;
      send_item(random_item());
    end
    sender_steady = 1'b0;
    sink_steady   = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // decode: small exponents, sign with zero mantissa, overflow edges, extremes
    send_item(decode_item(32'h0000_0000));
    send_item(decode_item(32'h0012_3456));
    send_item(decode_item(32'h0112_3456));
    send_item(decode_item(32'h0212_3456));
    send_item(decode_item(32'h0312_3456));
    send_item(decode_item(32'h0180_3456));
    send_item(decode_item(32'h0492_3456));
    send_item(decode_item(32'h1d00_ffff));
    send_item(decode_item(32'h2200_0001));
    send_item(decode_item(32'h2300_0001));
    send_item(decode_item(32'h2200_0100));
    send_item(decode_item(32'h2101_0000));
    send_item(decode_item(32'h20ff_ffff));
    send_item(decode_item(32'h2400_0001));
    send_item(decode_item(32'hff7f_ffff));
    send_item(decode_item(32'hffff_ffff));
    // encode: zero, renormalize, byte length edges, full width
    send_item(encode_item(256'h0, 1'b1));
    send_item(encode_item(256'h1, 1'b1));
    send_item(encode_item(256'h80, 1'b1));
    send_item(encode_item(256'h7f_ffff, 1'b0));
    send_item(encode_item(256'h80_0000, 1'b1));
    send_item(encode_item(256'h1234_5600, 1'b1));
    send_item(encode_item({256{1'b1}}, 1'b1));
    send_item(encode_item(256'h1 << 255, 1'b0));
    wait_drained();

    run_random(250, 100, 160, 1'b1);
    wait_drained();
    run_random(500, 150, 300, 1'b0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d decode and %0d encode transfers, %0d results checked",
             sb.n_decode, sb.n_encode, sb.n_checked);
    $display("with random stalls, a %0d-cycle receiver hold-off and %0d mismatches",
             SINK_HOLD, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
